/* rtl/barometric_pressure_compensation_macros.svh */
// Assertion helpers for the compensation pipeline.
// Both expect clk and arst_n in scope.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH

// Same-cycle implication
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BPC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bpc_pkg.sv */
package bpc_pkg;

	localparam int unsigned RAW_W   = 24;
	localparam int unsigned CAL_W   = 16;
	localparam int unsigned PRES_W  = 32;
	localparam int unsigned TEMP_W  = 16;
	localparam int unsigned CFG_IDX_W = 3;

	typedef logic [RAW_W-1:0]     raw_t;
	typedef logic [CAL_W-1:0]     cal_t;
	typedef logic signed [PRES_W-1:0] pres_t;
	typedef logic signed [TEMP_W-1:0] temp_t;

	// calibration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CAL_SENS_GAIN     = 3'd0,
		CAL_OFFSET        = 3'd1,
		CAL_SENS_TEMPCO   = 3'd2,
		CAL_OFFSET_TEMPCO = 3'd3,
		CAL_REF_TEMP      = 3'd4,
		CAL_TEMP_COEFF    = 3'd5
	} cal_idx_t;

	localparam logic [TEMP_W-1:0] TEMP_BASE = 16'd2000;

endpackage

/* rtl/bpc_in_if.sv */
interface bpc_in_if;
	logic          valid;
	logic          ready;
	bpc_pkg::raw_t raw_pressure;
	bpc_pkg::raw_t raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

/* rtl/bpc_out_if.sv */
interface bpc_out_if;
	logic           valid;
	logic           ready;
	bpc_pkg::pres_t pressure;
	bpc_pkg::temp_t temperature;

	modport source (output valid, output pressure, output temperature, input ready);
	modport sink   (input valid, input pressure, input temperature, output ready);
endinterface

/* rtl/bpc_cfg_if.sv */
interface bpc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bpc_pkg::CFG_IDX_W-1:0]  index;
	bpc_pkg::cal_t                  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/barometric_pressure_compensation.sv */
// A sample pair accepted at the input passes through stages s1 to s6; results.valid is valid_s6.
// Throughput: one pair per cycle while not stalled; six register stages, each holding its own
// valid bit, so a stalled output only backs up the stages that are full.
// The 24x35 pressure product is split into two narrower multipliers.
// Reset clears all stage valids and the six calibration words to zero.
`include "barometric_pressure_compensation_macros.svh"

module barometric_pressure_compensation (
	input  logic      clk,
	input  logic      arst_n,
	bpc_in_if.sink    samples,
	bpc_out_if.source results,
	bpc_cfg_if.sink   cfg
);

	localparam logic signed [41:0] RND_T = (42'sd1 <<< 23) - 42'sd1;
	localparam logic signed [41:0] RND_O = (42'sd1 <<< 6) - 42'sd1;
	localparam logic signed [41:0] RND_S = (42'sd1 <<< 7) - 42'sd1;
	localparam logic signed [59:0] RND_P = (60'sd1 <<< 21) - 60'sd1;
	localparam logic signed [39:0] RND_F = (40'sd1 <<< 15) - 40'sd1;

	bpc_pkg::cal_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	// stage payloads
	bpc_pkg::raw_t          d1_s1, d1_s2, d1_s3;
	logic signed [24:0]     dt_s1;
	logic signed [41:0]     tmul_s2, omul_s2, smul_s2;
	logic [15:0]            temp_s3, temp_s4, temp_s5, temp_s6;
	logic signed [35:0]     off_s3, off_s4;
	logic signed [34:0]     sens_s3;
	logic signed [42:0]     phi_s4;
	logic [40:0]            plo_s4;
	logic signed [39:0]     diff_s5;
	logic [31:0]            pres_s6;

	// combinational intermediates
	logic signed [24:0] dt_c;
	logic signed [41:0] tb_c, ob_c, sb_c, tq_c, oq_c, sq_c;
	logic [15:0]        temp_c;
	logic signed [35:0] off_c;
	logic signed [34:0] sens_c;
	logic signed [17:0] sens_hi;
	logic signed [59:0] prod_c, pb_c, pq_c;
	logic signed [39:0] diff_c, fb_c, fq_c;

	// configuration: always ready, unknown indexes ignored
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg.valid) begin
			unique case (bpc_pkg::cal_idx_t'(cfg.index))
				bpc_pkg::CAL_SENS_GAIN:     c1_q <= cfg.data;
				bpc_pkg::CAL_OFFSET:        c2_q <= cfg.data;
				bpc_pkg::CAL_SENS_TEMPCO:   c3_q <= cfg.data;
				bpc_pkg::CAL_OFFSET_TEMPCO: c4_q <= cfg.data;
				bpc_pkg::CAL_REF_TEMP:      c5_q <= cfg.data;
				bpc_pkg::CAL_TEMP_COEFF:    c6_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// per-stage enables: a stage loads when empty or when the next one moves
	assign en_s6 = !valid_s6 || results.ready;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign samples.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= samples.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	always_comb begin
		// dT
		dt_c = $signed({1'b0, samples.raw_temperature}) - $signed({1'b0, c5_q, 8'b0});

		// divisions truncate toward zero: bias negatives before the shift
		tb_c = tmul_s2 + (tmul_s2[41] ? RND_T : 42'sd0);
		ob_c = omul_s2 + (omul_s2[41] ? RND_O : 42'sd0);
		sb_c = smul_s2 + (smul_s2[41] ? RND_S : 42'sd0);
		tq_c = tb_c >>> 23;
		oq_c = ob_c >>> 6;
		sq_c = sb_c >>> 7;
		temp_c = tq_c[15:0] + bpc_pkg::TEMP_BASE;
		off_c  = $signed({3'b0, c2_q, 17'b0}) + oq_c[35:0];
		sens_c = $signed({3'b0, c1_q, 16'b0}) + sq_c[34:0];

		sens_hi = sens_s3[34:17];

		prod_c = $signed({phi_s4, 17'b0}) + $signed({19'b0, plo_s4});
		pb_c   = prod_c + (prod_c[59] ? RND_P : 60'sd0);
		pq_c   = pb_c >>> 21;
		diff_c = pq_c[39:0] - 40'(off_s4);

		fb_c = diff_s5 + (diff_s5[39] ? RND_F : 40'sd0);
		fq_c = fb_c >>> 15;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d1_s1 <= samples.raw_pressure;
			dt_s1 <= dt_c;
		end
		if (en_s2) begin
			d1_s2   <= d1_s1;
			tmul_s2 <= dt_s1 * $signed({1'b0, c6_q});
			omul_s2 <= dt_s1 * $signed({1'b0, c4_q});
			smul_s2 <= dt_s1 * $signed({1'b0, c3_q});
		end
		if (en_s3) begin
			d1_s3   <= d1_s2;
			temp_s3 <= temp_c;
			off_s3  <= off_c;
			sens_s3 <= sens_c;
		end
		if (en_s4) begin
			// D1*SENS as signed high part and unsigned low 17 bits
			phi_s4  <= $signed({1'b0, d1_s3}) * sens_hi;
			plo_s4  <= d1_s3 * sens_s3[16:0];
			off_s4  <= off_s3;
			temp_s4 <= temp_s3;
		end
		if (en_s5) begin
			diff_s5 <= diff_c;
			temp_s5 <= temp_s4;
		end
		if (en_s6) begin
			pres_s6 <= fq_c[31:0];
			temp_s6 <= temp_s5;
		end
	end

	assign results.valid       = valid_s6;
	assign results.pressure    = $signed(pres_s6);
	assign results.temperature = $signed(temp_s6);

	`BPC_ASSERT_IMP(a_ready_when_drained, !valid_s6, samples.ready, "input stalled with empty output stage")
	`BPC_ASSERT_NXT(a_accept_fills_s1, samples.valid && samples.ready, valid_s1, "accepted transaction lost")
	`BPC_ASSERT_NXT(a_s3_holds, valid_s3 && !en_s3, valid_s3 && $stable(sens_s3), "held stage 3 changed")

endmodule

/* tb/barometric_pressure_compensation_test.sv */
`timescale 1ns / 100ps

module barometric_pressure_compensation_test;
	import bpc_pkg::*;

	// indexes past the calibration map, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CAL_IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CAL_IDX_SPARE_HI = 3'd7;
	localparam int NUM_CAL = 6;
	localparam int RANDOM_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct packed {
		pres_t pressure;
		temp_t temperature;
	} reading_t;

	class compensation_scoreboard;
		cal_t        cal_words [NUM_CAL];
		reading_t    pending_readings [$];
		int unsigned fail_count;

		function new();
			foreach (cal_words[i])
				cal_words[i] = '0;
			fail_count = 0;
		endfunction

		function void set_cal(cal_idx_t idx, cal_t val);
			cal_words[idx] = val;
		endfunction

		function reading_t compensate(raw_t raw_press, raw_t raw_temp);
			longint   d1, d2, dt, t, off, sens, p;
			reading_t r;
			d1 = longint'(raw_press);
			d2 = longint'(raw_temp);
			dt = d2 - longint'(cal_words[CAL_REF_TEMP]) * 256;
			// signed division truncates toward zero
			t = longint'(TEMP_BASE) + (dt * longint'(cal_words[CAL_TEMP_COEFF])) / 8388608;
			off = longint'(cal_words[CAL_OFFSET]) * 131072
				+ (longint'(cal_words[CAL_OFFSET_TEMPCO]) * dt) / 64;
			sens = longint'(cal_words[CAL_SENS_GAIN]) * 65536
				+ (longint'(cal_words[CAL_SENS_TEMPCO]) * dt) / 128;
			p = ((d1 * sens) / 2097152 - off) / 32768;
			r.pressure = p[PRES_W-1:0];
			r.temperature = t[TEMP_W-1:0];
			return r;
		endfunction

		function void note_sample(raw_t raw_press, raw_t raw_temp);
			pending_readings.push_back(compensate(raw_press, raw_temp));
		endfunction

		function void check_result(pres_t pres, temp_t temp);
			reading_t exp_r;
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected transaction, pressure %0d temperature %0d",
					$time, pres, temp);
				fail_count++;
				return;
			end
			exp_r = pending_readings.pop_front();
			if (pres !== exp_r.pressure) begin
				$display("%0t: pressure expected %0d, got %0d", $time, exp_r.pressure, pres);
				fail_count++;
			end
			if (temp !== exp_r.temperature) begin
				$display("%0t: temperature expected %0d, got %0d",
					$time, exp_r.temperature, temp);
				fail_count++;
			end
		endfunction

		function bit drained();
			return pending_readings.size() == 0;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bpc_in_if  samples_if ();
	bpc_out_if results_if ();
	bpc_cfg_if cfg_if ();

	compensation_scoreboard sb;

	int ready_mode;
	int ready_hold;

	barometric_pressure_compensation dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output back-pressure: stretches of differing stall density
	always @(posedge clk) begin
		if (arst_n) begin
			if (ready_hold == 0) begin
				ready_mode = $urandom_range(0, 3);
				ready_hold = $urandom_range(20, 200);
			end
			ready_hold--;
			case (ready_mode)
				0: results_if.ready <= 1'b1;
				1: results_if.ready <= ($urandom_range(0, 1) == 1);
				2: results_if.ready <= ($urandom_range(0, 4) == 0);
				default: results_if.ready <= ($urandom_range(0, 15) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			sb.check_result(results_if.pressure, results_if.temperature);
	end

	task automatic send_sample(input raw_t raw_press, input raw_t raw_temp);
		samples_if.valid <= 1'b1;
		samples_if.raw_pressure <= raw_press;
		samples_if.raw_temperature <= raw_temp;
		do @(posedge clk); while (!samples_if.ready);
		sb.note_sample(raw_press, raw_temp);
	endtask

	// gap with junk on the payload
	task automatic idle_input(input int cycles);
		samples_if.valid <= 1'b0;
		repeat (cycles) begin
			samples_if.raw_pressure <= raw_t'($urandom);
			samples_if.raw_temperature <= raw_t'($urandom);
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		samples_if.valid <= 1'b0;
		do @(posedge clk); while (!sb.drained());
	endtask

	task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input cal_t val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx <= CAL_TEMP_COEFF)
			sb.set_cal(cal_idx_t'(idx), val);
	endtask

	// only called with the pipeline empty
	task automatic program_cal(input cal_t words [NUM_CAL], input bit with_spare);
		for (int i = 0; i < NUM_CAL; i++) begin
			write_cal(cal_idx_t'(i), words[i]);
			if (with_spare && i == 2)
				write_cal(CAL_IDX_SPARE_LO, cal_t'($urandom));
		end
		if (with_spare)
			write_cal(CAL_IDX_SPARE_HI, cal_t'($urandom));
		cfg_if.valid <= 1'b0;
	endtask

	function automatic cal_t pick_cal_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return cal_t'($urandom);
		endcase
	endfunction

	function automatic raw_t pick_raw();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return raw_t'($urandom);
		endcase
	endfunction

	// mostly near the reference temperature, as a real sensor reads
	function automatic raw_t pick_temp();
		raw_t ref_raw;
		ref_raw = raw_t'({sb.cal_words[CAL_REF_TEMP], 8'h00});
		case ($urandom_range(0, 3))
			0: return pick_raw();
			1: return ref_raw + raw_t'($urandom_range(0, 511)) - raw_t'(256);
			default: return ref_raw + raw_t'($urandom_range(0, 65535)) - raw_t'(32768);
		endcase
	endfunction

	task automatic feed_samples(input int count);
		int burst_left;
		burst_left = $urandom_range(1, 40);
		for (int i = 0; i < count; i++) begin
			send_sample(pick_raw(), pick_temp());
			burst_left--;
			if (burst_left == 0) begin
				idle_input($urandom_range(1, 12));
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 15) == 0)
					wait_drained();
			end
		end
		wait_drained();
	endtask

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		cal_t words [NUM_CAL];
		sb = new();
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.raw_pressure = '0;
		samples_if.raw_temperature = '0;
		results_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calibration still at reset
		send_sample('0, '0);
		send_sample('1, '1);
		send_sample(24'd6465444, 24'd8077636);
		wait_drained();

		// typical factory calibration, including samples with dT around zero
		words = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
		program_cal(words, 1'b0);
		send_sample(24'd6465444, 24'd8077636);
		send_sample('0, '0);
		send_sample('1, '1);
		send_sample('1, '0);
		send_sample('0, '1);
		send_sample(24'd123456, {16'd33464, 8'h00});
		send_sample(24'd8388608, {16'd33464, 8'h01});
		send_sample(24'd9000000, {16'd33464, 8'h00} - 24'd1);
		wait_drained();

		// all words at full scale: temperature wraps for low raw readings; spare indexes written too
		words = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		program_cal(words, 1'b1);
		send_sample('1, '1);
		send_sample('0, '0);
		send_sample('1, '0);
		send_sample('0, '1);
		send_sample(24'h800000, 24'h800000);
		wait_drained();

		words = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
		program_cal(words, 1'b0);
		send_sample('0, '0);
		send_sample('1, '1);
		send_sample('1, '0);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			foreach (words[i])
				words[i] = pick_cal_word();
			program_cal(words, $urandom_range(0, 2) == 0);
			feed_samples(ITEMS_PER_PHASE);
		end

		wait_drained();
		repeat (12) @(posedge clk);
		if (sb.fail_count == 0 && sb.drained())
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_in_if.sv
rtl/bpc_out_if.sv
rtl/bpc_cfg_if.sv
rtl/barometric_pressure_compensation.sv
tb/barometric_pressure_compensation_test.sv
